// File: design/kpd_pkg.sv
package kpd_pkg;

  // Keypad geometry and multi-tap limits
  localparam int KEY_COUNT = 16;
  localparam int KEY_W     = $clog2(KEY_COUNT);
  localparam int ROM_TAPS  = 5;
  localparam int TAP_W     = 3;
  localparam int COL_W     = $clog2(ROM_TAPS);

  localparam logic [TAP_W-1:0] TAPS_PER_KEY = 3'd5;
  localparam logic [3:0]       IDLE_PINS    = 4'hF;

  // Configuration register indexes
  localparam logic [1:0] REG_CONFIRM_SAMPLES = 2'd0;
  localparam logic [1:0] REG_HOLD_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_TAP_WINDOW      = 2'd2;

  // Register reset values
  localparam logic [1:0]  CONFIRM_SAMPLES_RST = 2'd2;
  localparam logic [15:0] HOLD_TIMEOUT_RST    = 16'd500;
  localparam logic [15:0] TAP_WINDOW_RST      = 16'd30;

  // {row, column} code of each key, rows driven low one at a time
  localparam logic [7:0] KEY_CODES [KEY_COUNT] = '{
    8'hE7, 8'hEB, 8'hED, 8'hEE, 8'hD7, 8'hDB, 8'hDD, 8'hDE,
    8'hB7, 8'hBB, 8'hBD, 8'hBE, 8'h77, 8'h7B, 8'h7D, 8'h7E
  };

  // Character per key and tap position (ASCII)
  localparam logic [6:0] CHAR_ROM [KEY_COUNT][ROM_TAPS] = '{
    '{7'h31, 7'h31, 7'h31, 7'h31, 7'h31},  // 1
    '{7'h32, 7'h61, 7'h62, 7'h63, 7'h32},  // 2 a b c
    '{7'h33, 7'h64, 7'h65, 7'h66, 7'h33},  // 3 d e f
    '{7'h24, 7'h24, 7'h24, 7'h24, 7'h24},  // $
    '{7'h34, 7'h67, 7'h68, 7'h69, 7'h34},  // 4 g h i
    '{7'h35, 7'h6A, 7'h6B, 7'h6C, 7'h35},  // 5 j k l
    '{7'h36, 7'h6D, 7'h6E, 7'h6F, 7'h36},  // 6 m n o
    '{7'h25, 7'h25, 7'h25, 7'h25, 7'h25},  // %
    '{7'h37, 7'h70, 7'h71, 7'h72, 7'h73},  // 7 p q r s
    '{7'h38, 7'h74, 7'h75, 7'h76, 7'h38},  // 8 t u v
    '{7'h39, 7'h77, 7'h78, 7'h79, 7'h7A},  // 9 w x y z
    '{7'h26, 7'h26, 7'h26, 7'h26, 7'h26},  // &
    '{7'h2E, 7'h2B, 7'h2D, 7'h2A, 7'h23},  // . + - * #
    '{7'h30, 7'h30, 7'h30, 7'h30, 7'h30},  // 0
    '{7'h40, 7'h40, 7'h40, 7'h40, 7'h40},  // @
    '{7'h5E, 7'h5E, 7'h5E, 7'h5E, 7'h5E}   // ^
  };

  // Map a scan code to its key; an unknown code maps to key 0
  function automatic logic [KEY_W-1:0] key_index(input logic [7:0] code);
    logic [KEY_W-1:0] idx;
    idx = '0;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (KEY_CODES[i] == code) idx = KEY_W'(i);
    end
    return idx;
  endfunction

  // Character for a key after a number of taps (taps >= 1), column clamped
  function automatic logic [6:0] char_lookup(input logic [KEY_W-1:0] key,
                                             input logic [TAP_W-1:0] taps);
    logic [COL_W-1:0] col;
    if (taps > TAP_W'(ROM_TAPS)) col = COL_W'(ROM_TAPS - 1);
    else                         col = COL_W'(taps - TAP_W'(1));
    return CHAR_ROM[key][col];
  endfunction

endpackage

// File: design/keypad_scan_multitap.sv
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ----------------------------------
// in        input      in_valid / in_stall  pin_sample
// out       output     out_valid/out_stall  read_columns, key_valid, key_char
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request is taken in ST_IDLE and its result is loaded into the output
// register from ST_EMIT, where a stalled output makes it wait.
// A tick whose tap window expires adds a pass of the single compare unit
// over the tap counters in ST_SCAN, one counter per cycle, before ST_EMIT.
// in_stall stays high until the result is loaded; a stalled output holds.
// Synchronous reset clears scan state, tap counters and out_valid (not the
// output payload) and restores the register defaults; cfg_ready is always high.
module keypad_scan_multitap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  pin_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        read_columns,
  output logic        key_valid,
  output logic [6:0]  key_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kpd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } seq_state_t;

  typedef enum logic [3:0] {
    PH_ROWS    = 4'b0001,
    PH_COLS    = 4'b0010,
    PH_RELEASE = 4'b0100,
    PH_COMMIT  = 4'b1000
  } phase_t;

  // Configuration
  logic [1:0]  confirm_samples;
  logic [15:0] hold_timeout;
  logic [15:0] tap_window;

  // Scan state
  seq_state_t       state;
  phase_t           phase, phase_next;
  logic [1:0]       confirm_count, confirm_count_next;
  logic [7:0]       key_code, key_code_next;
  logic [15:0]      hold_ticks, hold_ticks_next, hold_inc;
  logic [15:0]      window_ticks, window_ticks_next, window_load;
  logic [TAP_W-1:0] tap_counts [KEY_COUNT];

  // Scan pass over the tap counters
  logic [KEY_W-1:0] scan_idx;
  logic [KEY_W-1:0] rd_addr;
  logic [TAP_W-1:0] tap_rd;
  logic [1:0]       nz_count, nz_count_next;
  logic [KEY_W-1:0] found, found_next;
  logic [TAP_W-1:0] found_taps, found_taps_next;
  logic             scan_last;

  // Pending result
  logic       res_columns;
  logic       res_valid;
  logic [6:0] res_char;

  logic accept, commit, decide, out_load, tap_any;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign commit    = (phase == PH_COMMIT);
  assign scan_last = (scan_idx == KEY_W'(KEY_COUNT - 1));
  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);

  // One read port into the tap counters: pressed key on a tick, sweep on a scan
  assign rd_addr = (state == ST_SCAN) ? scan_idx : key_index(key_code);
  assign tap_rd  = tap_counts[rd_addr];

  // Phase logic of one tick
  always_comb begin
    hold_inc           = (&hold_ticks) ? hold_ticks : hold_ticks + 16'd1;
    phase_next         = phase;
    confirm_count_next = confirm_count;
    key_code_next      = key_code;
    hold_ticks_next    = hold_inc;
    case (phase)
      PH_ROWS: begin
        if (pin_sample != IDLE_PINS) begin
          if (confirm_count != 2'd3) confirm_count_next = confirm_count + 2'd1;
          if (confirm_count_next >= confirm_samples) begin
            key_code_next = {pin_sample, 4'h0};
            phase_next    = PH_COLS;
          end
        end else begin
          confirm_count_next = 2'd0;
          hold_ticks_next    = 16'd0;
        end
      end
      PH_COLS: begin
        if (pin_sample != IDLE_PINS) begin
          key_code_next = key_code | {4'h0, pin_sample};
          phase_next    = PH_RELEASE;
        end else if (hold_inc > hold_timeout) begin
          hold_ticks_next = 16'd0;
          phase_next      = PH_ROWS;
        end
      end
      PH_RELEASE: begin
        if (pin_sample == IDLE_PINS) phase_next = PH_COMMIT;
      end
      PH_COMMIT: begin
        key_code_next   = 8'h00;
        hold_ticks_next = 16'd0;
        phase_next      = PH_ROWS;
      end
      default: begin
        phase_next = PH_ROWS;
      end
    endcase
  end

  // Tap window: loaded on commit, then counted down in the same tick
  always_comb begin
    window_load       = commit ? tap_window : window_ticks;
    window_ticks_next = (window_load != 16'd0) ? window_load - 16'd1 : window_load;
    decide            = (window_load == 16'd1);
  end

  // Shared compare unit of the sweep
  always_comb begin
    nz_count_next   = nz_count;
    found_next      = found;
    found_taps_next = found_taps;
    if (tap_rd != '0) begin
      found_next      = scan_idx;
      found_taps_next = tap_rd;
      if (nz_count != 2'd2) nz_count_next = nz_count + 2'd1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_samples <= CONFIRM_SAMPLES_RST;
      hold_timeout    <= HOLD_TIMEOUT_RST;
      tap_window      <= TAP_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONFIRM_SAMPLES: confirm_samples <= cfg_data[1:0];
        REG_HOLD_TIMEOUT:    hold_timeout    <= cfg_data;
        REG_TAP_WINDOW:      tap_window      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, scan state and tap counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_ROWS;
      confirm_count <= 2'd0;
      key_code      <= 8'h00;
      hold_ticks    <= 16'd0;
      window_ticks  <= 16'd0;
      scan_idx      <= '0;
      nz_count      <= 2'd0;
      found         <= '0;
      found_taps    <= '0;
      res_columns   <= 1'b0;
      res_valid     <= 1'b0;
      res_char      <= 7'h00;
      for (int i = 0; i < KEY_COUNT; i++) tap_counts[i] <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase         <= phase_next;
            confirm_count <= confirm_count_next;
            key_code      <= key_code_next;
            hold_ticks    <= hold_ticks_next;
            window_ticks  <= window_ticks_next;
            res_columns   <= (phase_next == PH_COLS) || (phase_next == PH_RELEASE);
            res_valid     <= 1'b0;
            res_char      <= 7'h00;
            if (commit && (tap_rd < TAPS_PER_KEY)) begin
              tap_counts[rd_addr] <= tap_rd + TAP_W'(1);
            end
            if (decide) begin
              state    <= ST_SCAN;
              scan_idx <= '0;
              nz_count <= 2'd0;
              found    <= '0;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          nz_count   <= nz_count_next;
          found      <= found_next;
          found_taps <= found_taps_next;
          scan_idx   <= scan_idx + KEY_W'(1);
          if (scan_last) begin
            // one key with taps gives a character; every counter ends at zero
            res_valid <= (nz_count_next == 2'd1);
            res_char  <= (nz_count_next == 2'd1) ?
                         char_lookup(found_next, found_taps_next) : 7'h00;
            for (int i = 0; i < KEY_COUNT; i++) tap_counts[i] <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_columns <= res_columns;
      key_valid    <= res_valid;
      key_char     <= res_char;
    end
  end

  // Checks
  always_comb begin
    tap_any = 1'b0;
    for (int i = 0; i < KEY_COUNT; i++) tap_any = tap_any | (tap_counts[i] != '0);
  end

  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && scan_last |=> !tap_any)
    else $error("tap counters not cleared after a decision");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_SCAN) |-> (scan_idx == '0) && (nz_count == 2'd0))
    else $error("sweep did not start from the first counter");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> (key_char == 7'h00))
    else $error("character shown without a decision");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_valid |-> (key_char != 7'h00))
    else $error("decided character inconsistent");

  a_sweep_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (state == ST_SCAN) || (state == ST_EMIT))
    else $error("sweep left early");

endmodule

// File: bench/tb.sv
module tb;
  import kpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT = 500000;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  // scan code of each key, key 0 first
  localparam logic [0:15][7:0] SCAN_CODES = {
    8'hE7, 8'hEB, 8'hED, 8'hEE, 8'hD7, 8'hDB, 8'hDD, 8'hDE,
    8'hB7, 8'hBB, 8'hBD, 8'hBE, 8'h77, 8'h7B, 8'h7D, 8'h7E
  };

  // five characters per key, indexed by key * 5 + taps - 1
  localparam logic [0:79][7:0] TAP_CHARS =
    "111112abc23def3$$$$$4ghi45jkl56mno6%%%%%7pqrs8tuv89wxyz&&&&&.+-*#00000@@@@@^^^^^";

  typedef enum logic [1:0] {
    MODE_ROWS,
    MODE_COLS,
    MODE_HELD,
    MODE_COMMIT
  } scan_mode_t;

  typedef struct packed {
    logic       read_columns;
    logic       key_valid;
    logic [6:0] key_char;
  } tick_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  pin_sample = IDLE_PINS;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        read_columns;
  logic        key_valid;
  logic [6:0]  key_char;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_CONFIRM_SAMPLES;
  logic [15:0] cfg_data = '0;

  keypad_scan_multitap u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pin_sample   (pin_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_columns (read_columns),
    .key_valid    (key_valid),
    .key_char     (key_char),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // register copies
  logic [1:0]  need_hits   = CONFIRM_SAMPLES_RST;
  logic [15:0] hold_limit  = HOLD_TIMEOUT_RST;
  logic [15:0] window_len  = TAP_WINDOW_RST;

  // scanner state as predicted
  scan_mode_t  mode        = MODE_ROWS;
  logic [1:0]  row_hits    = '0;
  logic [7:0]  latched_code = '0;
  logic [15:0] held_ticks  = '0;
  logic [15:0] window_left = '0;
  logic [2:0]  tap_tally [KEY_COUNT];

  tick_outcome_t tick_outcomes[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int n_errors       = 0;
  int n_ticks        = 0;
  int n_chars        = 0;
  int n_abandoned    = 0;
  int n_cleared      = 0;
  int n_settings     = 0;
  int cycle_count    = 0;

  initial begin
    for (int i = 0; i < KEY_COUNT; i++) tap_tally[i] = '0;
  end

  // one scan tick of the keypad: update state, queue the outcome
  task automatic scan_tick(input logic [3:0] pins);
    int            key;
    int            found;
    int            busy;
    int            taps;
    tick_outcome_t res;
    res = '0;
    key = 0;
    found = 0;
    busy = 0;
    n_ticks++;
    if (held_ticks != 16'hFFFF) held_ticks++;
    case (mode)
      MODE_ROWS: begin
        if (pins != IDLE_PINS) begin
          if (row_hits < 2'd3) row_hits++;
          if (row_hits >= need_hits) begin
            latched_code = {pins, 4'h0};
            mode = MODE_COLS;
          end
        end else begin
          row_hits = '0;
          held_ticks = '0;
        end
      end
      MODE_COLS: begin
        if (pins != IDLE_PINS) begin
          latched_code = latched_code | {4'h0, pins};
          mode = MODE_HELD;
        end else if (held_ticks > hold_limit) begin
          held_ticks = '0;
          mode = MODE_ROWS;
          n_abandoned++;
        end
      end
      MODE_HELD: begin
        if (pins == IDLE_PINS) mode = MODE_COMMIT;
      end
      default: begin
        // unknown codes fall back to key 0
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
          if (SCAN_CODES[i] == latched_code) key = i;
        end
        if (tap_tally[key] < TAPS_PER_KEY) tap_tally[key]++;
        latched_code = '0;
        mode = MODE_ROWS;
        held_ticks = '0;
        window_left = window_len;
      end
    endcase

    // tap window: decide when it runs out
    if (window_left != 0) begin
      window_left--;
      if (window_left == 0) begin
        for (int i = 0; i < KEY_COUNT; i++) begin
          if (tap_tally[i] != 0) begin
            found = i;
            busy++;
          end
        end
        if (busy == 1) begin
          taps = (tap_tally[found] > 5) ? 5 : int'(tap_tally[found]);
          res.key_valid = 1'b1;
          res.key_char = TAP_CHARS[found * 5 + taps - 1][6:0];
          tap_tally[found] = '0;
          n_chars++;
        end else begin
          for (int i = 0; i < KEY_COUNT; i++) tap_tally[i] = '0;
          n_cleared++;
        end
      end
    end
    res.read_columns = (mode == MODE_COLS || mode == MODE_HELD);
    tick_outcomes.push_back(res);
  endtask

  // send one pin sample; entered and left at a falling edge
  task automatic drive_pins(input logic [3:0] pins);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      pin_sample <= 4'($urandom_range(0, 15));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pin_sample <= pins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_tick(pins);
    @(negedge clk);
  endtask

  // stop sending and wait for every outcome to drain
  task automatic settle();
    in_valid <= 1'b0;
    while (tick_outcomes.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CONFIRM_SAMPLES: need_hits = data[1:0];
      REG_HOLD_TIMEOUT:    hold_limit = data;
      REG_TAP_WINDOW:      window_len = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [15:0] confirm, input logic [15:0] hold,
                          input logic [15:0] window);
    write_reg(REG_CONFIRM_SAMPLES, confirm);
    write_reg(REG_HOLD_TIMEOUT, hold);
    write_reg(REG_TAP_WINDOW, window);
    write_reg(REG_UNUSED, 16'($urandom()));
    n_settings++;
  endtask

  // one key press following the predicted scan mode
  task automatic press_key(input logic [7:0] code, input int col_waits, input int extra_hold);
    int guard;
    guard = 0;
    while (mode == MODE_ROWS && guard < 6) begin
      drive_pins(code[7:4]);
      guard++;
    end
    for (int i = 0; i < col_waits && mode == MODE_COLS; i++) drive_pins(IDLE_PINS);
    while (mode == MODE_COLS) drive_pins(code[3:0]);
    for (int i = 0; i < extra_hold && mode == MODE_HELD; i++) begin
      drive_pins($urandom_range(0, 1) ? code[3:0] : 4'($urandom_range(0, 14)));
    end
    while (mode == MODE_HELD) drive_pins(IDLE_PINS);
    // commit tick ignores the pins
    if (mode == MODE_COMMIT) drive_pins(4'($urandom_range(0, 15)));
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) drive_pins(IDLE_PINS);
  endtask

  // register values after reset: two taps on the 2 key give 'a'
  task automatic test_register_defaults();
    src_idle_pct = 26;
    sink_stall_pct = 26;
    press_key(SCAN_CODES[1], 0, 0);
    press_key(SCAN_CODES[1], 0, 1);
    while (window_left != 0) drive_pins(IDLE_PINS);
  endtask

  task automatic test_special_cases();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    settle();
    // zero confirm count, immediate decision with a one-tick window
    set_regs(16'hFFFC, 16'd2, 16'd1);
    press_key(SCAN_CODES[15], 0, 0);
    // all pins low: unknown code counts as key 0
    press_key(8'h00, 0, 0);
    // no column answer past the hold timeout: press dropped
    press_key(SCAN_CODES[4], 4, 0);
    // window not running: taps pile up and saturate
    settle();
    write_reg(REG_TAP_WINDOW, 16'd0);
    repeat (6) press_key(SCAN_CODES[12], 0, 0);
    settle();
    write_reg(REG_TAP_WINDOW, 16'd1);
    press_key(SCAN_CODES[12], 0, 0);
    // two keys in one window: everything cleared
    settle();
    write_reg(REG_TAP_WINDOW, 16'd0);
    press_key(SCAN_CODES[0], 0, 0);
    press_key(SCAN_CODES[1], 0, 0);
    settle();
    write_reg(REG_TAP_WINDOW, 16'd1);
    press_key(SCAN_CODES[1], 0, 0);
    // saturated confirm count carries over the commit
    settle();
    write_reg(REG_CONFIRM_SAMPLES, 16'd3);
    press_key(SCAN_CODES[9], 0, 0);
    press_key(SCAN_CODES[10], 0, 0);
  endtask

  task automatic test_register_extremes();
    src_idle_pct = 46;
    sink_stall_pct = 46;
    settle();
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    press_key(SCAN_CODES[8], 3, 1);
    press_key(SCAN_CODES[8], 0, 0);
    idle_ticks(3);
    settle();
    set_regs(16'h0001, 16'h0001, 16'h8000);
    press_key(SCAN_CODES[13], 3, 0);
    press_key(SCAN_CODES[13], 0, 2);
  endtask

  task automatic pick_regs();
    logic [15:0] hold;
    logic [15:0] window;
    int          roll;
    hold = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 10));
    roll = $urandom_range(0, 19);
    if (roll == 0)      window = '0;
    else if (roll == 1) window = 16'($urandom());
    else                window = 16'($urandom_range(1, 30));
    set_regs(16'($urandom()), hold, window);
  endtask

  // random typing: mostly well-formed taps, some pin noise
  task automatic test_random_typing(input int n_items, input int src_pct, input int sink_pct);
    int  start;
    int  late;
    int  cap;
    int  key;
    bit  paused;
    logic [7:0] code;
    start = n_ticks;
    paused = 1'b0;
    settle();
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    pick_regs();
    while (n_ticks - start < n_items) begin
      if (!paused && n_ticks - start >= n_items / 2) begin
        // hold off until every outcome is in, then change settings
        paused = 1'b1;
        settle();
        pick_regs();
      end
      if ($urandom_range(0, 4) != 0) begin
        key = $urandom_range(0, KEY_COUNT - 1);
        code = SCAN_CODES[key];
        if ($urandom_range(0, 9) == 0) begin
          code = {4'($urandom_range(0, 14)), 4'($urandom_range(0, 14))};
        end
        repeat ($urandom_range(1, 6)) begin
          late = ($urandom_range(0, 4) == 0 && hold_limit < 20) ? int'(hold_limit) + 2
                                                                : $urandom_range(0, 2);
          press_key(code, late, $urandom_range(0, 3));
          idle_ticks($urandom_range(0, 2));
        end
        cap = (window_len != 0 && window_len < 40) ? int'(window_len) + 2 : 40;
        idle_ticks($urandom_range(0, cap));
      end else begin
        repeat ($urandom_range(1, 6)) drive_pins(4'($urandom_range(0, 15)));
      end
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // compare each accepted outcome with the oldest prediction
  always @(posedge clk) begin
    tick_outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tick_outcomes.size() == 0) begin
        $display("%0t: unexpected outcome rc=%0b kv=%0b ch=%h", $time,
                 read_columns, key_valid, key_char);
        n_errors++;
      end else begin
        want = tick_outcomes.pop_front();
        if (read_columns !== want.read_columns) begin
          $display("%0t: read_columns expected %0b got %0b", $time,
                   want.read_columns, read_columns);
          n_errors++;
        end
        if (key_valid !== want.key_valid) begin
          $display("%0t: key_valid expected %0b got %0b", $time, want.key_valid, key_valid);
          n_errors++;
        end
        if (key_char !== want.key_char) begin
          $display("%0t: key_char expected %h got %h", $time, want.key_char, key_char);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_register_defaults();
    test_special_cases();
    test_register_extremes();
    test_random_typing(200, 0, 0);
    test_random_typing(200, 46, 0);
    test_random_typing(200, 0, 46);
    test_random_typing(200, 26, 26);
    settle();
    repeat (40) @(negedge clk);
    $display("%0d scan ticks over %0d register settings", n_ticks, n_settings);
    $display("%0d characters, %0d dropped presses, %0d cleared windows, %0d errors",
             n_chars, n_abandoned, n_cleared, n_errors);
    if (n_errors == 0 && tick_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: keypad_scan_multitap.f
design/kpd_pkg.sv
design/keypad_scan_multitap.sv
bench/tb.sv
